[rtl/sorted_expiry_timer_queue_defines.svh]
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_defines
// assertion macros for the timer queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_EXPIRY_TIMER_QUEUE_DEFINES_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SEXQ_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sexq check failed");

// next-cycle implication, disabled in reset
`define SEXQ_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sexq next-cycle check failed");

`endif

[rtl/sexq_pkg.sv]
// ----------------------------------------------------------------------------
// sexq_pkg
// types and constants for the sorted expiry timer queue
// ----------------------------------------------------------------------------
package sexq_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int ID_W        = 16;
    localparam int EXP_W       = 32;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_ADJUST = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_DUP      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINSERT,
        ST_TICK
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [ID_W-1:0]    key_id;
        logic [EXP_W-1:0]   key_expire;
    } cell_ctl_t;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [EXP_W-1:0]   expire;
    } cell_data_t;

endpackage

[rtl/sexq_cell.sv]
// ----------------------------------------------------------------------------
// sexq_cell
// one timer slot of the sorted chain; shifts with its neighbors on command
// ----------------------------------------------------------------------------
module sexq_cell
    import sexq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  cell_data_t  prev_data,
    input  cell_data_t  next_data,
    input  logic        le_prev,
    input  logic        found_in,
    output cell_data_t  data,
    output logic        le,
    output logic        found_out
);

    logic             valid_reg, valid_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [EXP_W-1:0] expire_reg, expire_next;
    logic             match;

    assign data      = '{valid: valid_reg, id: id_reg, expire: expire_reg};
    assign le        = valid_reg && (expire_reg <= ctl.key_expire);
    assign match     = valid_reg && (id_reg == ctl.key_id);
    assign found_out = found_in | match;

    always_comb
    begin
        valid_next  = valid_reg;
        id_next     = id_reg;
        expire_next = expire_reg;
        case (ctl.cmd)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    if (le_prev)
                    begin
                        valid_next  = 1'b1;
                        id_next     = ctl.key_id;
                        expire_next = ctl.key_expire;
                    end
                    else
                    begin
                        valid_next  = prev_data.valid;
                        id_next     = prev_data.id;
                        expire_next = prev_data.expire;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (found_out)
                begin
                    valid_next  = next_data.valid;
                    id_next     = next_data.id;
                    expire_next = next_data.expire;
                end
            end
            CELL_POP:
            begin
                valid_next  = next_data.valid;
                id_next     = next_data.id;
                expire_next = next_data.expire;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        expire_reg <= expire_next;
    end

endmodule

[rtl/sorted_expiry_timer_queue.sv]
// add and delete: the accepted request is registered into the exec state, which drives a registered result strobe
// adjust: remove pass in exec, then insert pass in reinsert through the cell chain, then a registered result
// tick: one popped timer per cycle from the chain head, each result registered
// busy is low again in the same cycle as the final result strobe of an item, so a new request can be accepted
// reset clears every cell valid bit at once: the store starts empty, no clearing pass
// results cannot be stalled: each stands on the ports for one cycle with done high
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// sorted timer list built as a shifting chain of slot cells
// ----------------------------------------------------------------------------
`include "sorted_expiry_timer_queue_defines.svh"

module sorted_expiry_timer_queue
    import sexq_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [EXP_W-1:0]  new_expire,
    input  logic [EXP_W-1:0]  now_time,
    output logic              done,
    output logic [1:0]        status,
    output logic              expired_valid,
    output logic [ID_W-1:0]   expired_id,
    output logic              last
);

    state_t           state_reg, state_next;
    action_t          act_reg;
    logic [ID_W-1:0]  id_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] now_reg;

    logic             done_reg, done_next;
    status_t          status_reg, status_next;
    logic             ev_reg, ev_next;
    logic [ID_W-1:0]  eid_reg, eid_next;
    logic             last_reg, last_next;

    cell_ctl_t        ctl;
    cell_data_t       cdata [ENTRIES];
    logic             le    [ENTRIES];
    logic             found [ENTRIES];
    logic [ENTRIES-1:0] vld;

    logic accept;
    logic found_all;
    logic full;
    logic head_exp;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign found_all = found[ENTRIES-1];
    assign full      = cdata[ENTRIES-1].valid;
    assign head_exp  = le[0];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            cell_data_t prev_d, next_d;
            logic       le_p, fnd_p;
            if (gi == 0)
            begin : g_head
                assign prev_d = '0;
                assign le_p   = 1'b1;
                assign fnd_p  = 1'b0;
            end
            else
            begin : g_mid
                assign prev_d = cdata[gi-1];
                assign le_p   = le[gi-1];
                assign fnd_p  = found[gi-1];
            end
            if (gi == ENTRIES-1)
            begin : g_tail
                assign next_d = '0;
            end
            else
            begin : g_body
                assign next_d = cdata[gi+1];
            end
            sexq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .prev_data (prev_d),
                .next_data (next_d),
                .le_prev   (le_p),
                .found_in  (fnd_p),
                .data      (cdata[gi]),
                .le        (le[gi]),
                .found_out (found[gi])
            );
            assign vld[gi] = cdata[gi].valid;
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(action) == ACT_TICK) ? ST_TICK : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (act_reg == ACT_ADJUST && found_all) ? ST_REINSERT : ST_IDLE;
            end
            ST_REINSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                state_next = (head_exp && le[1]) ? ST_TICK : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.cmd        = CELL_HOLD;
        ctl.key_id     = id_reg;
        ctl.key_expire = exp_reg;
        done_next      = 1'b0;
        status_next    = STAT_OK;
        ev_next        = 1'b0;
        eid_next       = '0;
        last_next      = 1'b1;
        case (state_reg)
            ST_EXEC:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        done_next = 1'b1;
                        if (found_all)
                        begin
                            status_next = STAT_DUP;
                        end
                        else if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ctl.cmd = CELL_INSERT;
                        end
                    end
                    ACT_ADJUST:
                    begin
                        if (found_all)
                        begin
                            ctl.cmd = CELL_REMOVE;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_NOTFOUND;
                        end
                    end
                    ACT_DELETE:
                    begin
                        done_next = 1'b1;
                        if (found_all)
                        begin
                            ctl.cmd = CELL_REMOVE;
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        ctl.cmd = CELL_HOLD;
                    end
                endcase
            end
            ST_REINSERT:
            begin
                ctl.cmd   = CELL_INSERT;
                done_next = 1'b1;
            end
            ST_TICK:
            begin
                ctl.key_expire = now_reg;
                done_next      = 1'b1;
                if (head_exp)
                begin
                    ctl.cmd   = CELL_POP;
                    ev_next   = 1'b1;
                    eid_next  = cdata[0].id;
                    last_next = !le[1];
                end
            end
            default:
            begin
                ctl.cmd = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action_t'(action);
            id_reg  <= timer_id;
            exp_reg <= new_expire;
            now_reg <= now_time;
        end
        status_reg <= status_next;
        ev_reg     <= ev_next;
        eid_reg    <= eid_next;
        last_reg   <= last_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign expired_valid = ev_reg;
    assign expired_id    = eid_reg;
    assign last          = last_reg;

    // held timers stay packed at the head of the chain
    `SEXQ_CHECK(a_packed, 1'b1, ((vld >> 1) & ~vld) == '0)
    `SEXQ_CHECK_NEXT(a_busy_after_accept, accept, busy)
    `SEXQ_CHECK(a_pop_ok, done && expired_valid, status_reg == STAT_OK)
    `SEXQ_CHECK_NEXT(a_tick_burst, done && !last, done && expired_valid)
    `SEXQ_CHECK(a_reinsert_room, state_reg == ST_REINSERT, !full)

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted expiry timer queue: a directed table
// walks the edge cases, then random add, adjust, delete and tick traffic with
// a fill burst to a full store runs against a behavioral model of the sorted
// list, every strobed result compared field by field in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sexq_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int ID_POOL      = 128;
    localparam int STALL_LIMIT  = 4000;
    localparam int DIR_ROWS     = 23;

    typedef struct {
        status_t         st;
        logic            valid;
        logic [ID_W-1:0] id;
        logic            fin;
    } timer_result_t;

    typedef struct {
        action_t          act;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] expire;
        logic [EXP_W-1:0] now;
        bit               typed;
        status_t          st;
        logic             valid;
        logic [ID_W-1:0]  xid;
        logic             xlast;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       action = ACT_TICK;
    logic [ID_W-1:0]  timer_id = '0;
    logic [EXP_W-1:0] new_expire = '0;
    logic [EXP_W-1:0] now_time = '0;
    logic             done;
    logic [1:0]       status;
    logic             expired_valid;
    logic [ID_W-1:0]  expired_id;
    logic             last;

    logic [EXP_W-1:0] held_expire [ENTRIES];
    logic [ID_W-1:0]  held_id [ENTRIES];
    int               held_count = 0;

    timer_result_t    step_results[$];
    timer_result_t    expected_results[$];
    logic [ID_W-1:0]  id_pool [ID_POOL];
    int               mismatches = 0;
    int               stall_cycles = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ACT_TICK,   16'h0000, 32'h00000000, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADJUST, 16'h0005, 32'h00000010, 32'h00000000, 1'b1, STAT_NOTFOUND, 1'b0, 16'h0, 1'b1},
        '{ACT_DELETE, 16'h0005, 32'h00000000, 32'h00000000, 1'b1, STAT_NOTFOUND, 1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h0000, 32'h00000000, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'hFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h0000, 32'h00000007, 32'h00000000, 1'b1, STAT_DUP,      1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h1234, 32'h00000064, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h4321, 32'h00000064, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h00FF, 32'h00000032, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADJUST, 16'h1234, 32'h00000064, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADJUST, 16'hFFFF, 32'h00000014, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADJUST, 16'h0000, 32'h000000C8, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_TICK,   16'hABCD, 32'h00000000, 32'h00000063, 1'b0, STAT_OK,       1'b0, 16'h0, 1'b0},
        '{ACT_TICK,   16'h0000, 32'h00000000, 32'h00000063, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_DELETE, 16'h4321, 32'h00000000, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_DELETE, 16'h4321, 32'h00000000, 32'h00000000, 1'b1, STAT_NOTFOUND, 1'b0, 16'h0, 1'b1},
        '{ACT_TICK,   16'h0000, 32'h00000000, 32'hFFFFFFFF, 1'b0, STAT_OK,       1'b0, 16'h0, 1'b0},
        '{ACT_TICK,   16'h0000, 32'h00000000, 32'hFFFFFFFF, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'hAAAA, 32'hFFFFFFFF, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADD,    16'h5555, 32'h00000000, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_ADJUST, 16'h5555, 32'hFFFFFFFF, 32'h00000000, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_TICK,   16'h0000, 32'h00000000, 32'hFFFFFFFE, 1'b1, STAT_OK,       1'b0, 16'h0, 1'b1},
        '{ACT_TICK,   16'hFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b0, STAT_OK,       1'b0, 16'h0, 1'b0}
    };

    sorted_expiry_timer_queue #(.ENTRIES(ENTRIES)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .timer_id     (timer_id),
        .new_expire   (new_expire),
        .now_time     (now_time),
        .done         (done),
        .status       (status),
        .expired_valid(expired_valid),
        .expired_id   (expired_id),
        .last         (last)
    );

    always #4 clk = ~clk;

    function automatic int find_timer(logic [ID_W-1:0] id);
        for (int i = 0; i < held_count; i++)
            if (held_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void remove_timer(int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_expire[i] = held_expire[i + 1];
            held_id[i]     = held_id[i + 1];
        end
        held_count--;
    endfunction

    function automatic void insert_timer(logic [ID_W-1:0] id, logic [EXP_W-1:0] expire);
        int pos;
        pos = 0;
        while (pos < held_count && held_expire[pos] <= expire)
            pos++;
        for (int i = held_count; i > pos; i--)
        begin
            held_expire[i] = held_expire[i - 1];
            held_id[i]     = held_id[i - 1];
        end
        held_expire[pos] = expire;
        held_id[pos]     = id;
        held_count++;
    endfunction

    function automatic void push_result(status_t st, logic valid, logic [ID_W-1:0] id,
                                        logic fin);
        timer_result_t r;
        r.st    = st;
        r.valid = valid;
        r.id    = id;
        r.fin   = fin;
        step_results.push_back(r);
    endfunction

    function automatic void timer_queue_step(action_t act, logic [ID_W-1:0] id,
                                             logic [EXP_W-1:0] expire, logic [EXP_W-1:0] now);
        int pos;
        step_results.delete();
        case (act)
            ACT_ADD:
            begin
                if (find_timer(id) >= 0)
                    push_result(STAT_DUP, 1'b0, '0, 1'b1);
                else if (held_count >= ENTRIES)
                    push_result(STAT_FULL, 1'b0, '0, 1'b1);
                else
                begin
                    insert_timer(id, expire);
                    push_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            ACT_ADJUST, ACT_DELETE:
            begin
                pos = find_timer(id);
                if (pos < 0)
                    push_result(STAT_NOTFOUND, 1'b0, '0, 1'b1);
                else
                begin
                    remove_timer(pos);
                    if (act == ACT_ADJUST)
                        insert_timer(id, expire);
                    push_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            default:
            begin
                while (held_count > 0 && held_expire[0] <= now)
                begin
                    push_result(STAT_OK, 1'b1, held_id[0], 1'b0);
                    remove_timer(0);
                end
                if (step_results.size() == 0)
                    push_result(STAT_OK, 1'b0, '0, 1'b1);
                else
                    step_results[step_results.size() - 1].fin = 1'b1;
            end
        endcase
    endfunction

    task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                             input logic [EXP_W-1:0] expire, input logic [EXP_W-1:0] now,
                             input bit typed, input timer_result_t typed_res,
                             input bit may_idle, input bit drain);
        int gap;
        start      <= 1'b1;
        action     <= act;
        timer_id   <= id;
        new_expire <= expire;
        now_time   <= now;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        timer_queue_step(act, id, expire, now);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        gap = 0;
        if (may_idle)
            while ($urandom_range(0, 99) < 19)
                gap++;
        if (drain)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain && expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d valid %0b id %h last %0b",
                             status, expired_valid, expired_id, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st || expired_valid !== want.valid ||
                    expired_id !== want.id || last !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d valid %0b id %h last %0b, %s %0d %0b %h %0b",
                                 want.st, want.valid, want.id, want.fin, "got",
                                 status, expired_valid, expired_id, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        action_t          act;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] expire;
        logic [EXP_W-1:0] now;
        logic [EXP_W-1:0] clock_base;
        timer_result_t    typed_res;
        int               roll;
        bit               fresh;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL; i++)
        begin
            fresh = 1'b0;
            while (!fresh)
            begin
                id_pool[i] = ID_W'($urandom);
                fresh = 1'b1;
                for (int j = 0; j < i; j++)
                    if (id_pool[j] == id_pool[i])
                        fresh = 1'b0;
            end
        end
        clock_base = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[r])
        begin
            typed_res.st    = dir_table[r].st;
            typed_res.valid = dir_table[r].valid;
            typed_res.id    = dir_table[r].xid;
            typed_res.fin   = dir_table[r].xlast;
            send_item(dir_table[r].act, dir_table[r].id, dir_table[r].expire,
                      dir_table[r].now, dir_table[r].typed, typed_res, 1'b1, 1'b0);
        end

        // fill burst drives the store to full, then one tick empties it
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (n >= 150 && n < 227)
                act = ACT_ADD;
            else if (n == 227)
                act = ACT_TICK;
            else if (roll < 40)
                act = ACT_ADD;
            else if (roll < 60)
                act = ACT_ADJUST;
            else if (roll < 75)
                act = ACT_DELETE;
            else
                act = ACT_TICK;

            roll = $urandom_range(0, 99);
            if (act == ACT_TICK)
                id = ID_W'($urandom);
            else if (n == 225 && held_count > 0)
                id = held_id[$urandom_range(0, held_count - 1)];
            else if (n >= 150 && n < 227)
            begin
                id = id_pool[$urandom_range(0, ID_POOL - 1)];
                while (find_timer(id) >= 0)
                    id = id_pool[$urandom_range(0, ID_POOL - 1)];
            end
            else if (act != ACT_ADD && held_count > 0 && roll < 75)
                id = held_id[$urandom_range(0, held_count - 1)];
            else if (roll < 90)
                id = id_pool[$urandom_range(0, ID_POOL - 1)];
            else
                id = ID_W'($urandom);

            roll = $urandom_range(0, 99);
            if (roll < 70)
                expire = clock_base + $urandom_range(0, 60);
            else if (roll < 80)
                expire = '0;
            else if (roll < 90)
                expire = '1;
            else
                expire = $urandom;

            roll = $urandom_range(0, 99);
            if (act != ACT_TICK)
                now = $urandom;
            else if (n == 227 || (roll >= 80 && roll < 90))
                now = '1;
            else if (roll < 80)
                now = clock_base + $urandom_range(0, 30);
            else
                now = $urandom;
            if (act == ACT_TICK)
                clock_base = clock_base + $urandom_range(0, 20);

            send_item(act, id, expire, now, 1'b0, typed_res,
                      !(n >= 260 && n < 360), n == 100 || n == 228);
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
